// ===== design/hsvrgb_pkg.sv =====
package hsvrgb_pkg;

  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;
  localparam int CHAN_W = 8;
  localparam int HR_W   = 6;   // hue remainder within a sector, 0..59
  localparam int SEC_W  = 3;
  localparam int TERM_W = 13;  // weights over 6000, never above 6000
  localparam int NUM_W  = 20;  // brightness times weight, never above 600000
  localparam int X_W    = 28;  // numerator times 255
  localparam int RECIP_W = 29;
  localparam int PROD_W = X_W + RECIP_W;

  localparam int HueTurn    = 360;
  localparam int SectorSpan = 60;
  localparam int PctMax     = 100;
  localparam int FullTurn   = 6000;
  localparam int ChanShift  = 8;    // times 255 is times 256 minus one

  // floor(x / 600000) for x below 2^28 is (x * RecipMul) >> RecipShift
  localparam int RecipShift = 48;
  localparam logic [RECIP_W-1:0] RecipMul = 29'd469124962;

  typedef enum logic [SEC_W-1:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

endpackage

// ===== design/hsvrgb_frontend.sv =====
module hsvrgb_frontend (
  input  logic                              clk,
  input  logic [1:0]                        en,
  input  logic [hsvrgb_pkg::HUE_W-1:0]      hue,
  input  logic [hsvrgb_pkg::PCT_W-1:0]      saturation,
  input  logic [hsvrgb_pkg::PCT_W-1:0]      brightness,
  output hsvrgb_pkg::sector_t               sector,
  output logic [hsvrgb_pkg::PCT_W-1:0]      bright,
  output logic [hsvrgb_pkg::TERM_W-1:0]     term_p,
  output logic [hsvrgb_pkg::TERM_W-1:0]     term_q,
  output logic [hsvrgb_pkg::TERM_W-1:0]     term_t
);
  import hsvrgb_pkg::*;

  logic [HUE_W-1:0] hue_w;
  sector_t          sec_c;
  logic [HR_W-1:0]  hr_c;
  logic [PCT_W-1:0] sat_c;
  logic [PCT_W-1:0] val_c;

  sector_t          sec0;
  logic [HR_W-1:0]  hr0;
  logic [PCT_W-1:0] sat0;
  logic [PCT_W-1:0] val0;

  // a full turn and anything clamped to it fold back onto the red sector
  assign hue_w = (hue >= HUE_W'(HueTurn)) ? '0 : hue;
  assign sat_c = (saturation > PCT_W'(PctMax)) ? PCT_W'(PctMax) : saturation;
  assign val_c = (brightness > PCT_W'(PctMax)) ? PCT_W'(PctMax) : brightness;

  always_comb begin
    sec_c = SEC_RED;
    hr_c  = HR_W'(hue_w);
    for (int k = 1; k < 6; k++) begin
      if (hue_w >= HUE_W'(k * SectorSpan)) begin
        sec_c = sector_t'(SEC_W'(k));
        hr_c  = HR_W'(hue_w - HUE_W'(k * SectorSpan));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sec0 <= sec_c;
      hr0  <= hr_c;
      sat0 <= sat_c;
      val0 <= val_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sector <= sec0;
      bright <= val0;
      term_p <= TERM_W'(FullTurn) - TERM_W'(sat0) * TERM_W'(SectorSpan);
      term_q <= TERM_W'(FullTurn) - TERM_W'(hr0) * TERM_W'(sat0);
      term_t <= TERM_W'(FullTurn)
                - (TERM_W'(SectorSpan) - TERM_W'(hr0)) * TERM_W'(sat0);
    end
  end

endmodule

// ===== design/hsvrgb_scaler.sv =====
module hsvrgb_scaler (
  input  logic                              clk,
  input  logic [2:0]                        en,
  input  logic [hsvrgb_pkg::PCT_W-1:0]      bright,
  input  logic [hsvrgb_pkg::TERM_W-1:0]     term,
  output logic [hsvrgb_pkg::CHAN_W-1:0]     chan
);
  import hsvrgb_pkg::*;

  logic [NUM_W-1:0]  num;
  logic [X_W-1:0]    scaled;
  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      num <= NUM_W'(bright) * NUM_W'(term);
    end
    if (en[1]) begin
      scaled <= (X_W'(num) << ChanShift) - X_W'(num);
    end
    // exact floor division by 600000 through the reciprocal
    if (en[2]) begin
      prod <= PROD_W'(scaled) * PROD_W'(RecipMul);
    end
  end

  assign chan = prod[RecipShift +: CHAN_W];

endmodule

// ===== design/hsv_to_rgb_pixel.sv =====
// HSV to RGB pixel converter.
// Input channel: hue (degrees 0..360), saturation and brightness (percent
// 0..100) with in_valid/in_ready; a transaction completes when both are high.
// Values above range are clamped, and hue 360 is treated as 0.
// Output channel: red, green, blue (8 bits each) with out_valid/out_ready.
// One result leaves for every transaction accepted, in order.
// Each pixel passes through six register stages: clamp and sector decode,
// sector weights, brightness product, scaling by 255, reciprocal multiply
// for the division by 600000, then channel select into the output register.
// Throughput is one pixel per clock while the receiver holds out_ready high.
// Each stage carries a valid bit and advances when it is empty or the stage
// after it advances, so a stalled receiver fills the pipeline and then drops
// in_ready; no transaction is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; data registers are not
// cleared.
module hsv_to_rgb_pixel (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [hsvrgb_pkg::HUE_W-1:0]      hue,
  input  logic [hsvrgb_pkg::PCT_W-1:0]      saturation,
  input  logic [hsvrgb_pkg::PCT_W-1:0]      brightness,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hsvrgb_pkg::CHAN_W-1:0]     red,
  output logic [hsvrgb_pkg::CHAN_W-1:0]     green,
  output logic [hsvrgb_pkg::CHAN_W-1:0]     blue
);
  import hsvrgb_pkg::*;

  localparam int NSTAGE = 6;

  logic [NSTAGE-1:0]  vld;
  logic [NSTAGE-1:0]  en;

  sector_t            sec1;
  sector_t            sec2;
  sector_t            sec3;
  sector_t            sec4;
  logic [PCT_W-1:0]   bright1;
  logic [TERM_W-1:0]  term_p;
  logic [TERM_W-1:0]  term_q;
  logic [TERM_W-1:0]  term_t;
  logic [CHAN_W-1:0]  ch_v;
  logic [CHAN_W-1:0]  ch_p;
  logic [CHAN_W-1:0]  ch_q;
  logic [CHAN_W-1:0]  ch_t;

  // a stage advances when it holds nothing or its successor advances
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  hsvrgb_frontend u_front (
    .clk        (clk),
    .en         (en[1:0]),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .sector     (sec1),
    .bright     (bright1),
    .term_p     (term_p),
    .term_q     (term_q),
    .term_t     (term_t)
  );

  hsvrgb_scaler u_lane_v (
    .clk    (clk),
    .en     (en[4:2]),
    .bright (bright1),
    .term   (TERM_W'(FullTurn)),
    .chan   (ch_v)
  );

  hsvrgb_scaler u_lane_p (
    .clk    (clk),
    .en     (en[4:2]),
    .bright (bright1),
    .term   (term_p),
    .chan   (ch_p)
  );

  hsvrgb_scaler u_lane_q (
    .clk    (clk),
    .en     (en[4:2]),
    .bright (bright1),
    .term   (term_q),
    .chan   (ch_q)
  );

  hsvrgb_scaler u_lane_t (
    .clk    (clk),
    .en     (en[4:2]),
    .bright (bright1),
    .term   (term_t),
    .chan   (ch_t)
  );

  // carry the sector alongside the lanes
  always_ff @(posedge clk) begin
    if (en[2]) begin
      sec2 <= sec1;
    end
    if (en[3]) begin
      sec3 <= sec2;
    end
    if (en[4]) begin
      sec4 <= sec3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      case (sec4)
        SEC_RED: begin
          red <= ch_v; green <= ch_t; blue <= ch_p;
        end
        SEC_YELLOW: begin
          red <= ch_q; green <= ch_v; blue <= ch_p;
        end
        SEC_GREEN: begin
          red <= ch_p; green <= ch_v; blue <= ch_t;
        end
        SEC_CYAN: begin
          red <= ch_p; green <= ch_q; blue <= ch_v;
        end
        SEC_BLUE: begin
          red <= ch_t; green <= ch_p; blue <= ch_v;
        end
        default: begin
          red <= ch_v; green <= ch_p; blue <= ch_q;
        end
      endcase
    end
  end

endmodule

// ===== bench/pixel_check_pkg.sv =====
package pixel_check_pkg;

  import hsvrgb_pkg::*;

  localparam int ChanMax   = 255;
  localparam int DenomAll  = FullTurn * PctMax;   // 600000

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_rgb_t;

  class pixel_scoreboard;

    pixel_rgb_t pending_rgb[$];
    int mismatches = 0;

    function logic [CHAN_W-1:0] scale_to_byte(longint unsigned num);
      return CHAN_W'((num * ChanMax) / DenomAll);
    endfunction

    function pixel_rgb_t convert_hsv(logic [HUE_W-1:0] hue_in,
                                     logic [PCT_W-1:0] sat_in,
                                     logic [PCT_W-1:0] bri_in);
      longint unsigned h, s, v, hr;
      logic [CHAN_W-1:0] wv, wp, wq, wt;
      sector_t sec;
      pixel_rgb_t px;
      h = (hue_in > HueTurn) ? HueTurn : hue_in;
      s = (sat_in > PctMax) ? PctMax : sat_in;
      v = (bri_in > PctMax) ? PctMax : bri_in;
      // a full turn is the red sector again
      if (h >= HueTurn) h = 0;
      hr  = h % SectorSpan;
      sec = sector_t'(h / SectorSpan);
      wv = scale_to_byte(v * FullTurn);
      wp = scale_to_byte(v * (PctMax - s) * SectorSpan);
      wq = scale_to_byte(v * (FullTurn - hr * s));
      wt = scale_to_byte(v * (FullTurn - (SectorSpan - hr) * s));
      case (sec)
        SEC_RED:     px = '{red: wv, green: wt, blue: wp};
        SEC_YELLOW:  px = '{red: wq, green: wv, blue: wp};
        SEC_GREEN:   px = '{red: wp, green: wv, blue: wt};
        SEC_CYAN:    px = '{red: wp, green: wq, blue: wv};
        SEC_BLUE:    px = '{red: wt, green: wp, blue: wv};
        default:     px = '{red: wv, green: wp, blue: wq};
      endcase
      return px;
    endfunction

    function void note_pixel(logic [HUE_W-1:0] hue_in, logic [PCT_W-1:0] sat_in,
                             logic [PCT_W-1:0] bri_in);
      pending_rgb.push_back(convert_hsv(hue_in, sat_in, bri_in));
    endfunction

    function void check_pixel(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                              logic [CHAN_W-1:0] blue);
      pixel_rgb_t want;
      if (pending_rgb.size() == 0) begin
        $error("pixel: unexpected result, actual %0d %0d %0d", red, green, blue);
        mismatches++;
        return;
      end
      want = pending_rgb.pop_front();
      if (red !== want.red) begin
        $error("red: expected %0d, actual %0d", want.red, red);
        mismatches++;
      end
      if (green !== want.green) begin
        $error("green: expected %0d, actual %0d", want.green, green);
        mismatches++;
      end
      if (blue !== want.blue) begin
        $error("blue: expected %0d, actual %0d", want.blue, blue);
        mismatches++;
      end
    endfunction

    function int waiting();
      return pending_rgb.size();
    endfunction

  endclass

endpackage

// ===== bench/testbench.sv =====
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import hsvrgb_pkg::*;
  import pixel_check_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [HUE_W-1:0] hue = '0;
  logic [PCT_W-1:0] saturation = '0;
  logic [PCT_W-1:0] brightness = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CHAN_W-1:0] red, green, blue;

  int send_idle_pct = 25;
  int recv_idle_pct = 73;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  pixel_scoreboard board = new();

  hsv_to_rgb_pixel u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one pixel and hold it until the transaction completes.
  task automatic send_pixel(logic [HUE_W-1:0] h, logic [PCT_W-1:0] s,
                            logic [PCT_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(h, s, v);
  endtask

  // Mostly in-range pixels, with some clamped values in every field.
  task automatic send_random(int count);
    logic [HUE_W-1:0] h;
    logic [PCT_W-1:0] s, v;
    repeat (count) begin
      h = ($urandom_range(99) < 15) ? HUE_W'($urandom_range(511, 0))
                                    : HUE_W'($urandom_range(HueTurn, 0));
      s = ($urandom_range(99) < 15) ? PCT_W'($urandom_range(127, 0))
                                    : PCT_W'($urandom_range(PctMax, 0));
      v = ($urandom_range(99) < 15) ? PCT_W'($urandom_range(127, 0))
                                    : PCT_W'($urandom_range(PctMax, 0));
      send_pixel(h, s, v);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_pixel(red, green, blue);
  end

  // Receiver: random back-pressure, or a long hold when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sector edges, hue wrap and clamping, grey, black, field extremes
    send_pixel(0, 100, 100);
    send_pixel(59, 100, 100);
    send_pixel(60, 100, 100);
    send_pixel(119, 100, 100);
    send_pixel(120, 100, 100);
    send_pixel(179, 100, 100);
    send_pixel(180, 100, 100);
    send_pixel(239, 100, 100);
    send_pixel(240, 100, 100);
    send_pixel(299, 100, 100);
    send_pixel(300, 100, 100);
    send_pixel(359, 100, 100);
    send_pixel(360, 100, 100);
    send_pixel(361, 80, 90);
    send_pixel(511, 127, 127);
    send_pixel(200, 0, 77);
    send_pixel(30, 100, 0);
    send_pixel(45, 101, 127);
    send_pixel(100, 127, 101);
    send_pixel(256, 64, 63);
    send_pixel(255, 63, 64);
    send_pixel(150, 50, 50);
    send_pixel(330, 37, 85);
    send_pixel(0, 0, 0);

    send_random(230);
    wait_all_results();

    send_idle_pct = 73;
    recv_idle_pct = 25;
    send_random(230);

    // no idling; stall the receiver so the pipeline fills and in_ready drops
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    send_random(60);
    send_random(160);

    wait_all_results();
    repeat (DrainCycles) @(posedge clk);
    if (board.mismatches == 0 && board.waiting() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
